// ===== sv/kit_pkg.sv =====
// Shared types and constants for the key intern table.
package kit_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_BITS    = 32;
   localparam int KEY_FIELD_W = 32;
   localparam int ID_FIELD_W  = 9;
   localparam int ID_W        = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W       = (ID_W > ID_FIELD_W) ? ID_W : ID_FIELD_W;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_LOOKUP   = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_NEW    = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [KEY_FIELD_W-1:0] key;
      logic [ID_FIELD_W-1:0]  query_id;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [ID_FIELD_W-1:0]  entry_id;
      logic [KEY_FIELD_W-1:0] entry_key;
   } rsp_payload_type;

   typedef struct packed {
      logic                vld;
      logic [1:0]          op;
      logic [KEY_BITS-1:0] key;
      logic [CMP_W-1:0]    qid;
      logic                done;
      logic [1:0]          status;
      logic [CMP_W-1:0]    id;
      logic [KEY_BITS-1:0] rkey;
   } tok_type;

endpackage

// ===== sv/kit_cell.sv =====
// One table entry: a stored key, its occupied bit and one stage of the request chain.
module kit_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [kit_pkg::CMP_W-1:0] cell_id,
   input  kit_pkg::tok_type          prev_tok,
   output kit_pkg::tok_type          next_tok
);
   import kit_pkg::*;

   tok_type             tok_ff;
   tok_type             tok_in;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                occ_ff;
   logic                occ_in;

   always_comb begin
      tok_in = prev_tok;
      key_in = key_ff;
      occ_in = occ_ff;
      if (prev_tok.vld) begin
         case (prev_tok.op)
            OP_REGISTER: begin
               if (!prev_tok.done) begin
                  if (occ_ff && (key_ff == prev_tok.key)) begin
                     tok_in.done   = 1'b1;
                     tok_in.status = ST_HIT;
                     tok_in.id     = cell_id;
                  end else if (!occ_ff) begin
                     key_in        = prev_tok.key;
                     occ_in        = 1'b1;
                     tok_in.done   = 1'b1;
                     tok_in.status = ST_NEW;
                     tok_in.id     = cell_id;
                  end
               end
            end
            OP_LOOKUP: begin
               if (!prev_tok.done && (prev_tok.qid == cell_id)) begin
                  tok_in.done = 1'b1;
                  if (occ_ff) begin
                     tok_in.status = ST_HIT;
                     tok_in.rkey   = key_ff;
                  end else begin
                     tok_in.status = ST_REJECT;
                  end
               end
            end
            OP_CLEAR: begin
               occ_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
         occ_ff     <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff <= key_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

// ===== sv/key_intern_table.sv =====
// Top level of the key intern table: request entry, cell chain and result register.
// Each request travels down a chain of TABLE_DEPTH cells, one cell per cycle unless stalled;
// the cells carry ids 1 to TABLE_DEPTH and each holds the key with its id. A register
// request takes the id of the occupied cell whose key matches, or claims the first free
// cell; it is rejected for a zero key, or for a full table with no match. A lookup picks
// up the key of the cell whose id it names, and is rejected if that cell is free or absent.
// A clear drops every occupied bit as it passes. Later requests trail earlier ones, so
// each sees the table as left by those before it. The chain takes a new request every
// cycle unless a waiting result stalls it; results pass from the last cell to a register.
// Both sides stall together while a result waits. The table is empty right after reset.
module key_intern_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kit_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kit_pkg::rsp_payload_type rsp_data
);
   import kit_pkg::*;

   tok_type         chain [TABLE_DEPTH+1];
   tok_type         entry_tok;
   tok_type         last_tok;
   logic            advance;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      entry_tok        = '0;
      entry_tok.vld    = req_valid;
      entry_tok.op     = req_data.req_type;
      entry_tok.key    = KEY_BITS'(req_data.key);
      entry_tok.qid    = CMP_W'(req_data.query_id);
      case (req_data.req_type)
         OP_REGISTER: begin
            if (entry_tok.key == '0) begin
               entry_tok.done   = 1'b1;
               entry_tok.status = ST_REJECT;
            end
         end
         OP_LOOKUP: begin
         end
         OP_CLEAR: begin
            entry_tok.done   = 1'b1;
            entry_tok.status = ST_HIT;
         end
         default: begin
            entry_tok.done   = 1'b1;
            entry_tok.status = ST_REJECT;
         end
      endcase
   end

   assign chain[0] = entry_tok;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      kit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_id  (CMP_W'(i + 1)),
         .prev_tok (chain[i]),
         .next_tok (chain[i+1])
      );
   end

   assign last_tok = chain[TABLE_DEPTH];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = last_tok.vld;
         if (last_tok.done) begin
            rsp_data_in.status    = last_tok.status;
            rsp_data_in.entry_id  = ID_FIELD_W'(last_tok.id);
            rsp_data_in.entry_key = KEY_FIELD_W'(last_tok.rkey);
         end else begin
            rsp_data_in.status    = ST_REJECT;
            rsp_data_in.entry_id  = '0;
            rsp_data_in.entry_key = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/kit_checker.sv =====
// Port-level checks for the key intern table and their bind to the top level.
module kit_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input kit_pkg::rsp_payload_type rsp_data
);
   import kit_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed before transfer");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_REJECT)
         |-> (rsp_data.entry_id == '0) && (rsp_data.entry_key == '0))
      else $error("rejected result carries data");

   a_new_has_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NEW)
         |-> (rsp_data.entry_id != '0) && (rsp_data.entry_key == '0))
      else $error("new entry without id");

   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

endmodule

bind key_intern_table kit_checker u_kit_checker (.*);
